@@ sv/aptd_pkg.sv @@
// Package: word types and constants for the authentication packet token deframer.
`timescale 1ns / 1ps

package aptd_pkg;

  localparam int unsigned TokLenW = 24;
  localparam int unsigned TokOffW = 4;
  localparam int unsigned AccW    = 64;

  // length-encoded integer lead bytes
  localparam logic [7:0] LeadLimit = 8'hfb;
  localparam logic [7:0] LeadLen2  = 8'hfc;
  localparam logic [7:0] LeadLen3  = 8'hfd;
  localparam logic [7:0] LeadLen8  = 8'hfe;

  localparam logic ModeFramed   = 1'b0;
  localparam logic ModeVerbatim = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic               token_valid;
    logic [TokOffW-1:0] token_offset;
    logic [TokLenW-1:0] token_length;
  } out_word_t;

endpackage

@@ sv/aptd_in_reg.sv @@
// Input register stage of the token deframer.
`timescale 1ns / 1ps

module aptd_in_reg
  import aptd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_word_t in_data_i,
  input  logic     adv_i,
  output logic     valid_o,
  output in_word_t word_o
);

  logic     valid_q, valid_d;
  in_word_t word_q;

  assign in_ready_o = !valid_q || adv_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      word_q <= in_data_i;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

@@ sv/aptd_parser.sv @@
// Packet parse state and result logic of the token deframer.
`timescale 1ns / 1ps

module aptd_parser
  import aptd_pkg::*;
#(
  parameter int unsigned LEN_BITS = 24
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_word_t  word_i,
  input  logic      mode_i,
  output out_word_t res_o
);

  localparam logic [2:0] PhCap   = 3'd0;
  localparam logic [2:0] PhLead  = 3'd1;
  localparam logic [2:0] PhExtra = 3'd2;
  localparam logic [2:0] PhBody  = 3'd3;
  localparam logic [2:0] PhBad   = 3'd4;

  localparam logic [LEN_BITS-1:0] LenMax = '1;
  localparam int unsigned MaxW = (LEN_BITS > TokLenW) ? LEN_BITS : TokLenW;

  logic [LEN_BITS-1:0] cnt_q, cnt_d;
  logic [2:0]          phase_q, phase_d;
  logic [3:0]          extra_q, extra_d;
  logic [2:0]          idx_q, idx_d;
  logic [LEN_BITS-1:0] accum_q, accum_d;
  logic                ovf_q, ovf_d;
  logic [3:0]          hdr_q, hdr_d;

  // state after this byte is parsed
  logic [2:0]          p_phase;
  logic [3:0]          p_extra;
  logic [2:0]          p_idx;
  logic [LEN_BITS-1:0] p_accum;
  logic                p_ovf;
  logic [3:0]          p_hdr;

  logic [7:0]          b;
  logic [AccW-1:0]     shifted;
  logic [4:0]          consumed;
  logic [LEN_BITS:0]   len;
  logic [LEN_BITS:0]   rem;
  logic                in_range;
  logic                framed_ok;
  logic [LEN_BITS-1:0] verb_len;
  logic [MaxW-1:0]     len_ext;

  assign b       = word_i.data_byte;
  assign shifted = AccW'(b) << {idx_q, 3'b000};

  always_comb begin
    p_phase = phase_q;
    p_extra = extra_q;
    p_idx   = idx_q;
    p_accum = accum_q;
    p_ovf   = ovf_q;
    p_hdr   = hdr_q;
    unique case (phase_q)
      PhCap: begin
        p_phase = PhLead;
      end
      PhLead: begin
        priority if (b < LeadLimit) begin
          p_accum = LEN_BITS'(b);
          p_ovf   = 1'b0;
          p_hdr   = 4'd1;
          p_phase = PhBody;
        end else if (b == LeadLen2 || b == LeadLen3 || b == LeadLen8) begin
          p_extra = (b == LeadLen2) ? 4'd2 : (b == LeadLen3) ? 4'd3 : 4'd8;
          p_hdr   = p_extra + 4'd1;
          p_accum = '0;
          p_ovf   = 1'b0;
          p_idx   = 3'd0;
          p_phase = PhExtra;
        end else begin
          p_phase = PhBad;
        end
      end
      PhExtra: begin
        p_accum = accum_q | shifted[LEN_BITS-1:0];
        p_ovf   = ovf_q | (|shifted[AccW-1:LEN_BITS]);
        p_idx   = idx_q + 3'd1;
        p_extra = extra_q - 4'd1;
        if (p_extra == 4'd0) begin
          p_phase = PhBody;
        end
      end
      default: begin
      end
    endcase
  end

  assign consumed = 5'd1 + {1'b0, p_hdr};
  assign len      = {1'b0, cnt_q} + {{LEN_BITS{1'b0}}, 1'b1};
  assign rem      = len - (LEN_BITS+1)'(consumed);
  assign in_range = (cnt_q != LenMax);

  assign framed_ok = (p_phase == PhBody) && !p_ovf
                  && ((LEN_BITS+1)'(consumed) <= len)
                  && ({1'b0, p_accum} <= rem);

  assign verb_len = (b == 8'd0) ? cnt_q : cnt_q + {{(LEN_BITS-1){1'b0}}, 1'b1};

  always_comb begin
    res_o   = '0;
    len_ext = '0;
    if (in_range) begin
      if (mode_i == ModeVerbatim) begin
        res_o.token_valid = 1'b1;
        len_ext           = MaxW'(verb_len);
      end else if (framed_ok) begin
        res_o.token_valid  = 1'b1;
        res_o.token_offset = TokOffW'(consumed);
        len_ext            = MaxW'(p_accum);
      end
    end
    res_o.token_length = len_ext[TokLenW-1:0];
  end

  always_comb begin
    cnt_d   = cnt_q;
    phase_d = phase_q;
    extra_d = extra_q;
    idx_d   = idx_q;
    accum_d = accum_q;
    ovf_d   = ovf_q;
    hdr_d   = hdr_q;
    if (step_i) begin
      if (word_i.last_byte) begin
        cnt_d   = '0;
        phase_d = PhCap;
        extra_d = '0;
        idx_d   = '0;
        accum_d = '0;
        ovf_d   = 1'b0;
        hdr_d   = '0;
      end else begin
        if (in_range) begin
          cnt_d = cnt_q + {{(LEN_BITS-1){1'b0}}, 1'b1};
        end
        phase_d = p_phase;
        extra_d = p_extra;
        idx_d   = p_idx;
        accum_d = p_accum;
        ovf_d   = p_ovf;
        hdr_d   = p_hdr;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      phase_q <= PhCap;
      extra_q <= '0;
      idx_q   <= '0;
      accum_q <= '0;
      ovf_q   <= 1'b0;
      hdr_q   <= '0;
    end else begin
      cnt_q   <= cnt_d;
      phase_q <= phase_d;
      extra_q <= extra_d;
      idx_q   <= idx_d;
      accum_q <= accum_d;
      ovf_q   <= ovf_d;
      hdr_q   <= hdr_d;
    end
  end

endmodule

@@ sv/auth_packet_token_deframer.sv @@
// A word is parsed from the input register; a last byte's result goes to the output register.
// Throughput: one byte word per cycle, stalled only while a result waits in the output register.
// The parse step is one pass of lead-byte decode plus a (LEN_BITS+1)-wide subtract and compare.
// Reset: async active low; clears mode, packet state, input and output valid.
// Top level: authentication packet token deframer.
`timescale 1ns / 1ps

module auth_packet_token_deframer
  import aptd_pkg::*;
#(
  parameter int unsigned LEN_BITS = 24
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i
);

  logic      mode_q, mode_d;
  logic      word_vld;
  in_word_t  word;
  logic      adv;
  out_word_t res;
  logic      out_valid_q, out_valid_d;
  out_word_t out_data_q;

  assign adv = word_vld && (!word.last_byte || !out_valid_q || out_ready_i);

  aptd_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .adv_i      (adv),
    .valid_o    (word_vld),
    .word_o     (word)
  );

  aptd_parser #(
    .LEN_BITS (LEN_BITS)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .word_i (word),
    .mode_i (mode_q),
    .res_o  (res)
  );

  assign mode_d = cfg_we_i ? cfg_wdata_i : mode_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (adv && word.last_byte) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ModeFramed;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && word.last_byte) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef NO_ASSERTIONS
  a_ready_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> word_vld && word.last_byte && out_valid_q)
    else $error("input stalled without a pending result");

  a_invalid_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.token_valid |->
      out_data_o.token_offset == '0 && out_data_o.token_length == '0)
    else $error("invalid result carries nonzero fields");

  a_offset_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.token_offset != '0 |-> out_data_o.token_offset >= 4'd2)
    else $error("framed offset below header size");

  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && word.last_byte |=> out_valid_o)
    else $error("last byte did not produce a result");
`endif

endmodule
